// ===== rtl/core/sfrc_pkg.sv =====
// shared types, codes and constants of the serial frame receiver
package sfrc_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0] GAP_SAT = 16'hFFFF;
  localparam logic [15:0] MIN_LEN = 16'd5;
  localparam logic [15:0] OPCODE_POS = 16'd4;

  localparam logic       FUNC_BYTE = 1'b0;
  localparam logic       FUNC_TICK = 1'b1;

  localparam logic       KIND_BODY = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_LENGTH   = 2'd2;

  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_GAP_TIMEOUT   = 2'd2;
  localparam logic [1:0] REG_MAX_LENGTH    = 2'd3;

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'h55;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'hFF;
  localparam logic [15:0] GAP_TIMEOUT_RST   = 16'd100;
  localparam logic [15:0] MAX_LENGTH_RST    = 16'd64;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_LEN0 = 3'd2,
    PH_LEN1 = 3'd3,
    PH_TYPE = 3'd4,
    PH_ID0  = 3'd5,
    PH_ID1  = 3'd6,
    PH_BODY = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [15:0] gap_timeout_ticks;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic       restart;
    logic [7:0] rx_byte;
  } qent_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_offset;
    logic [1:0]  status;
    logic [7:0]  frame_type;
    logic [15:0] frame_id;
    logic [7:0]  frame_opcode;
    logic [15:0] frame_length;
  } res_t;

endpackage

// ===== rtl/core/sfrc_if.sv =====
// request and result channels of the serial frame receiver
interface sfrc_item_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface sfrc_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_offset;
  logic [1:0]  status;
  logic [7:0]  frame_type;
  logic [15:0] frame_id;
  logic [7:0]  frame_opcode;
  logic [15:0] frame_length;

  modport source (output valid, output kind, output data_byte, output byte_offset,
                  output status, output frame_type, output frame_id,
                  output frame_opcode, output frame_length, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_offset,
                input status, input frame_type, input frame_id,
                input frame_opcode, input frame_length, output ready);
endinterface

// ===== rtl/core/sfrc_front.sv =====
// front end: gap tick counter and timeout tagging of received bytes
module sfrc_front (
  input  logic                clk,
  input  logic                rst,
  sfrc_item_if.sink           item,
  input  logic [15:0]         gap_timeout_ticks,
  input  logic                q_ready,
  output logic                push,
  output sfrc_pkg::qent_t     push_entry
);
  import sfrc_pkg::*;

  logic [15:0] gap_ticks;
  logic        accept;

  assign item.ready = q_ready;
  assign accept = item.valid && item.ready;
  assign push = accept && (item.func == FUNC_BYTE);
  assign push_entry.rx_byte = item.rx_byte;
  assign push_entry.restart = gap_ticks > gap_timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks <= '0;
    end else if (accept) begin
      if (item.func == FUNC_TICK) begin
        if (gap_ticks != GAP_SAT) begin
          gap_ticks <= gap_ticks + 16'd1;
        end
      end else begin
        gap_ticks <= '0;
      end
    end
  end
endmodule

// ===== rtl/core/sfrc_queue.sv =====
// short request queue between front and back end
module sfrc_queue #(
  parameter int DEPTH = sfrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sfrc_pkg::qent_t push_entry,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output sfrc_pkg::qent_t head
);
  import sfrc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  qent_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign not_full  = count != FULL;
  assign not_empty = count != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end
endmodule

// ===== rtl/core/sfrc_back.sv =====
// back end: frame parser, checksum and registered result stage
module sfrc_back (
  input  logic            clk,
  input  logic            rst,
  input  sfrc_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  sfrc_pkg::qent_t q_head,
  output logic            pop,
  sfrc_result_if.source   result
);
  import sfrc_pkg::*;

  phase_t      phase, phase_next, phase_eff;
  logic [15:0] length_field, length_field_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  type_field, type_field_next;
  logic [15:0] id_field, id_field_next;
  logic [7:0]  opcode_field, opcode_field_next;
  logic        res_valid;
  res_t        res, res_next;
  logic        res_load;

  logic [7:0]  b;
  logic [15:0] count_inc;
  logic [15:0] offset;
  logic [7:0]  sum_add;
  logic [7:0]  opcode_now;

  assign pop       = q_valid && (!res_valid || result.ready);
  assign b         = q_head.rx_byte;
  assign phase_eff = q_head.restart ? PH_HDR0 : phase;
  assign count_inc = byte_count + 16'd1;
  assign offset    = byte_count - OPCODE_POS;
  assign sum_add   = running_sum + b;
  assign opcode_now = (offset == '0) ? b : opcode_field;

  always_comb begin
    phase_next        = phase;
    length_field_next = length_field;
    byte_count_next   = byte_count;
    running_sum_next  = running_sum;
    type_field_next   = type_field;
    id_field_next     = id_field;
    opcode_field_next = opcode_field;
    res_load          = 1'b0;
    res_next          = res;
    if (pop) begin
      phase_next = phase_eff;
      case (phase_eff)
        PH_HDR0: begin
          if (b == cfg.header_first) begin
            phase_next = PH_HDR1;
          end
        end
        PH_HDR1: begin
          phase_next = (b == cfg.header_second) ? PH_LEN0 : PH_HDR0;
        end
        PH_LEN0: begin
          length_field_next = {8'h00, b};
          byte_count_next   = '0;
          running_sum_next  = b;
          type_field_next   = '0;
          id_field_next     = '0;
          opcode_field_next = '0;
          phase_next        = PH_LEN1;
        end
        PH_LEN1: begin
          length_field_next = length_field | {b, 8'h00};
          byte_count_next   = count_inc;
          running_sum_next  = sum_add;
          phase_next        = PH_TYPE;
        end
        PH_TYPE: begin
          type_field_next  = b;
          byte_count_next  = count_inc;
          running_sum_next = sum_add;
          phase_next       = PH_ID0;
        end
        PH_ID0: begin
          id_field_next    = {8'h00, b};
          byte_count_next  = count_inc;
          running_sum_next = sum_add;
          phase_next       = PH_ID1;
        end
        PH_ID1: begin
          id_field_next    = id_field | {b, 8'h00};
          byte_count_next  = count_inc;
          running_sum_next = sum_add;
          phase_next       = PH_BODY;
        end
        default: begin
          opcode_field_next     = opcode_now;
          byte_count_next       = count_inc;
          res_load              = 1'b1;
          res_next.data_byte    = b;
          res_next.byte_offset  = offset;
          res_next.frame_type   = type_field;
          res_next.frame_id     = id_field;
          res_next.frame_opcode = opcode_now;
          res_next.frame_length = length_field;
          if (count_inc >= length_field) begin
            res_next.kind = KIND_END;
            if (length_field < MIN_LEN || length_field > cfg.max_length) begin
              res_next.status = ST_LENGTH;
            end else if (sum_add != 8'h00) begin
              res_next.status = ST_CHECKSUM;
            end else begin
              res_next.status = ST_OK;
            end
            phase_next = PH_HDR0;
          end else begin
            res_next.kind    = KIND_BODY;
            res_next.status  = ST_OK;
            running_sum_next = sum_add;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      length_field <= '0;
      byte_count   <= '0;
      running_sum  <= '0;
      type_field   <= '0;
      id_field     <= '0;
      opcode_field <= '0;
    end else begin
      phase        <= phase_next;
      length_field <= length_field_next;
      byte_count   <= byte_count_next;
      running_sum  <= running_sum_next;
      type_field   <= type_field_next;
      id_field     <= id_field_next;
      opcode_field <= opcode_field_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.kind         = res.kind;
  assign result.data_byte    = res.data_byte;
  assign result.byte_offset  = res.byte_offset;
  assign result.status       = res.status;
  assign result.frame_type   = res.frame_type;
  assign result.frame_id     = res.frame_id;
  assign result.frame_opcode = res.frame_opcode;
  assign result.frame_length = res.frame_length;
endmodule

// ===== rtl/core/serial_frame_receiver_checksum_unit.sv =====
// top level of the serial frame receiver: configuration registers and wiring
// throughput: one request (byte or tick) per cycle while the queue is not full, set by the parser step
// a body byte is registered in the queue and then in the output register before its result is valid
// ticks and header or field bytes give no result; a stalled result holds the parser
// after queue_depth further bytes the input stops taking requests until result drains
// reset: synchronous, back to header hunt, fields cleared, registers to defaults
module serial_frame_receiver_checksum_unit #(
  parameter int QUEUE_DEPTH = sfrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sfrc_item_if.sink   item,
  sfrc_result_if.source result,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);
  import sfrc_pkg::*;

  cfg_t  cfg;
  logic  q_ready;
  logic  push;
  qent_t push_entry;
  logic  pop;
  logic  q_valid;
  qent_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first      <= HEADER_FIRST_RST;
      cfg.header_second     <= HEADER_SECOND_RST;
      cfg.gap_timeout_ticks <= GAP_TIMEOUT_RST;
      cfg.max_length        <= MAX_LENGTH_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_HEADER_FIRST:  cfg.header_first      <= wr_data[7:0];
        REG_HEADER_SECOND: cfg.header_second     <= wr_data[7:0];
        REG_GAP_TIMEOUT:   cfg.gap_timeout_ticks <= wr_data;
        REG_MAX_LENGTH:    cfg.max_length        <= wr_data;
        default:           cfg                   <= cfg;
      endcase
    end
  end

  sfrc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .item              (item),
    .gap_timeout_ticks (cfg.gap_timeout_ticks),
    .q_ready           (q_ready),
    .push              (push),
    .push_entry        (push_entry)
  );

  sfrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (q_ready),
    .pop        (pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  sfrc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .result  (result)
  );
endmodule
